/* rtl/gds_pkg.sv */
package gds_pkg;

  // Request operation codes
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_RUN   = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  // Cell kinds as stored
  localparam logic [1:0] KIND_OPEN    = 2'd0;
  localparam logic [1:0] KIND_BLOCKED = 2'd1;
  localparam logic [1:0] KIND_SOURCE  = 2'd2;
  localparam logic [1:0] KIND_SPARE   = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_ROWS   = 3'd0;
  localparam logic [2:0] REG_COLS   = 3'd1;
  localparam logic [2:0] REG_SOURCE = 3'd2;
  localparam logic [2:0] REG_COEFF  = 3'd3;
  localparam logic [2:0] REG_SWEEPS = 3'd4;

endpackage

/* rtl/grid_diffusion_stencil_unit.sv */
// Write, read and clear requests: a write stores the kind and answers; a read fetches the cell, then
//   answers; a clear zeroes both field buffers over all cells and answers. Run request: sweep_count
//   sweeps over rows*cols cells; an open cell with three passable neighbors divides by three in 4 steps.
// One request at a time; the one read port of each field and kind memory sets the per-cell cost.
// Reset (synchronous, rst_n low) starts a clearing pass over all MAX_ROWS*MAX_COLS cells that
//   zeroes both field buffers and the kind store; no request is taken until it ends.
module grid_diffusion_stencil_unit #(
  parameter int MAX_ROWS    = 128,
  parameter int MAX_COLS    = 128,
  parameter int FIELD_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  gds_pkg::op_t        in_operation,
  input  logic [6:0]          in_row,
  input  logic [6:0]          in_col,
  input  logic [1:0]          in_cell_kind,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_field_value,
  output logic                out_done_res,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import gds_pkg::*;

  localparam int FW    = FIELD_WIDTH;
  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int SW    = FW + 3;            // sum of four neighbor differences
  localparam int TW    = FW + 2;            // centre plus mean
  localparam int PW    = TW + 16;           // coefficient product
  localparam int XW    = (FW > 32) ? FW : 32;

  localparam logic signed [XW-1:0] F_MAX_X   = XW'((64'sd1 <<< (FW - 1)) - 64'sd1);
  localparam logic signed [XW-1:0] F_MIN_X   = -F_MAX_X - XW'(1);
  localparam logic signed [XW-1:0] I32_MAX_X = XW'(64'sd2147483647);
  localparam logic signed [XW-1:0] I32_MIN_X = -I32_MAX_X - XW'(1);
  localparam logic [TW-1:0]        HALF_T    = TW'(64'd1 << (FW - 1));

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_LOOK, S_LOOK2, S_NB, S_CALC, S_DIV, S_MUL, S_SAT, S_WR, S_RESP
  } state_t;

  // Memories
  logic [1:0]           kind_mem [CELLS];
  logic signed [FW-1:0] fa_mem   [CELLS];
  logic signed [FW-1:0] fb_mem   [CELLS];
  logic [1:0]           kd_q;
  logic signed [FW-1:0] fa_q, fb_q, src_q;

  // Configuration
  logic [7:0]         rows_cfg_r, cols_cfg_r, sweeps_cfg_r;
  logic signed [31:0] source_cfg_r;
  logic [15:0]        coeff_cfg_r;

  // Control and datapath registers
  state_t               state_r, state_nxt;
  logic                 clr_kind_r, clr_kind_nxt;
  logic [AW-1:0]        clr_addr_r, clr_addr_nxt;
  logic                 cur_a_r, cur_a_nxt;
  logic [7:0]           sw_left_r, sw_left_nxt;
  logic [RW-1:0]        r_r, r_nxt, rows_m1_r, rows_m1_nxt;
  logic [CW-1:0]        c_r, c_nxt, cols_m1_r, cols_m1_nxt;
  logic [AW-1:0]        rbase_r, rbase_nxt, last_base_r, last_base_nxt;
  logic [AW-1:0]        req_addr_r, req_addr_nxt;
  logic                 req_in_r, req_in_nxt;
  logic [2:0]           step_r, step_nxt;
  logic [1:0]           kind_c_r, kind_c_nxt;
  logic signed [FW-1:0] cen_r, cen_nxt;
  logic signed [SW-1:0] sum_r, sum_nxt;
  logic [2:0]           cnt_r, cnt_nxt;
  logic signed [TW-1:0] t_r, t_nxt;
  logic [PW-1:0]        prod_r, prod_nxt;
  logic                 tneg_r, tneg_nxt;
  logic signed [FW-1:0] wdata_r, wdata_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic signed [31:0]   out_value_r, out_value_nxt;

  // Combinational helpers
  logic                 accept;
  logic                 in_inside;
  logic [AW-1:0]        in_addr;
  logic [AW-1:0]        cell_addr, up_base, dn_base, rd_addr;
  logic [CW-1:0]        c_left, c_right;
  logic                 sum_neg;
  logic [SW-1:0]        sum_mag, mean_mag;
  logic signed [SW-1:0] mean, t_full;
  logic [TW-1:0]        t_mag, q_mag;
  logic signed [FW-1:0] src_sat;
  logic signed [XW-1:0] src_x, rd_x;
  logic                 div_start, div_done;
  logic [SW-1:0]        div_quo;
  logic                 kwe, fwe_a, fwe_b;
  logic [AW-1:0]        kwa, fwa;
  logic [1:0]           kwd;
  logic signed [FW-1:0] fwd;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_field_value = out_value_r;
  assign out_done_res    = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r   <= 8'd128;
      cols_cfg_r   <= 8'd128;
      source_cfg_r <= 32'sd65536;
      coeff_cfg_r  <= 16'd58982;
      sweeps_cfg_r <= 8'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROWS:   rows_cfg_r   <= cfg_data[7:0];
        REG_COLS:   cols_cfg_r   <= cfg_data[7:0];
        REG_SOURCE: source_cfg_r <= cfg_data;
        REG_COEFF:  coeff_cfg_r  <= cfg_data[15:0];
        REG_SWEEPS: sweeps_cfg_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Request cell address; cells beyond the store are not touched
  assign in_inside = (int'(in_row) < MAX_ROWS) && (int'(in_col) < MAX_COLS);
  assign in_addr   = AW'(int'(in_row) * MAX_COLS + int'(in_col));

  // Wrapped neighbor addressing over the active grid
  assign cell_addr = rbase_r + AW'(c_r);
  assign up_base   = (r_r == '0) ? last_base_r : rbase_r - AW'(MAX_COLS);
  assign dn_base   = (r_r == rows_m1_r) ? '0 : rbase_r + AW'(MAX_COLS);
  assign c_left    = (c_r == '0) ? cols_m1_r : c_r - 1'b1;
  assign c_right   = (c_r == cols_m1_r) ? '0 : c_r + 1'b1;

  always_comb begin
    rd_addr = cell_addr;
    if (state_r == S_LOOK) begin
      rd_addr = req_addr_r;
    end else if (state_r == S_NB) begin
      case (step_r)
        3'd1:    rd_addr = up_base + AW'(c_r);
        3'd2:    rd_addr = dn_base + AW'(c_r);
        3'd3:    rd_addr = rbase_r + AW'(c_left);
        3'd4:    rd_addr = rbase_r + AW'(c_right);
        default: rd_addr = cell_addr;
      endcase
    end
  end

  // Memory write ports
  always_comb begin
    kwe = (state_r == S_CLR && clr_kind_r) ||
          (accept && in_operation == OP_WRITE && in_inside);
    kwa = (state_r == S_CLR) ? clr_addr_r : in_addr;
    kwd = (state_r == S_CLR || in_cell_kind == KIND_SPARE) ? KIND_OPEN : in_cell_kind;
    fwe_a = (state_r == S_CLR) || (state_r == S_WR && !cur_a_r);
    fwe_b = (state_r == S_CLR) || (state_r == S_WR && cur_a_r);
    fwa   = (state_r == S_CLR) ? clr_addr_r : cell_addr;
    fwd   = (state_r == S_CLR) ? '0 : wdata_r;
  end

  always_ff @(posedge clk) begin
    if (kwe) begin
      kind_mem[kwa] <= kwd;
    end
    kd_q <= kind_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (fwe_a) begin
      fa_mem[fwa] <= fwd;
    end
    fa_q <= fa_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (fwe_b) begin
      fb_mem[fwa] <= fwd;
    end
    fb_q <= fb_mem[rd_addr];
  end

  assign src_q = cur_a_r ? fa_q : fb_q;

  // Source value and read value limited to their ranges
  assign src_x   = XW'(source_cfg_r);
  assign src_sat = (src_x > F_MAX_X) ? FW'(F_MAX_X) :
                   (src_x < F_MIN_X) ? FW'(F_MIN_X) : FW'(src_x);
  assign rd_x    = XW'(src_q);

  // Mean over passable neighbors, truncated toward zero
  assign sum_neg = sum_r[SW-1];
  assign sum_mag = sum_neg ? SW'(-sum_r) : SW'(sum_r);
  always_comb begin
    case (cnt_r)
      3'd1:    mean_mag = sum_mag;
      3'd2:    mean_mag = sum_mag >> 1;
      3'd3:    mean_mag = div_quo;
      3'd4:    mean_mag = sum_mag >> 2;
      default: mean_mag = '0;
    endcase
    mean   = sum_neg ? -$signed(mean_mag) : $signed(mean_mag);
    t_full = SW'(cen_r) + mean;
  end

  assign t_mag = t_r[TW-1] ? TW'(-t_r) : TW'(t_r);
  assign q_mag = prod_r[PW-1:16];

  assign div_start = (state_r == S_CALC) && (kind_c_r != KIND_BLOCKED) &&
                     (kind_c_r != KIND_SOURCE) && (cnt_r == 3'd3);

  gds_div #(.W(SW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_mag),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_kind_nxt  = clr_kind_r;
    clr_addr_nxt  = clr_addr_r;
    cur_a_nxt     = cur_a_r;
    sw_left_nxt   = sw_left_r;
    r_nxt         = r_r;
    c_nxt         = c_r;
    rows_m1_nxt   = rows_m1_r;
    cols_m1_nxt   = cols_m1_r;
    rbase_nxt     = rbase_r;
    last_base_nxt = last_base_r;
    req_addr_nxt  = req_addr_r;
    req_in_nxt    = req_in_r;
    step_nxt      = step_r;
    kind_c_nxt    = kind_c_r;
    cen_nxt       = cen_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    t_nxt         = t_r;
    prod_nxt      = prod_r;
    tneg_nxt      = tneg_r;
    wdata_nxt     = wdata_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;

    case (state_r)
      S_CLR: begin
        // Sweep every entry; a reset pass also opens every cell
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(CELLS - 1)) begin
          clr_addr_nxt = '0;
          if (clr_kind_r) begin
            clr_kind_nxt = 1'b0;
            state_nxt    = S_IDLE;
          end else begin
            out_value_nxt = '0;
            out_valid_nxt = 1'b1;
            state_nxt     = S_RESP;
          end
        end
      end

      S_IDLE: begin
        if (accept) begin
          req_addr_nxt  = in_addr;
          req_in_nxt    = in_inside;
          out_value_nxt = '0;
          case (in_operation)
            OP_WRITE: begin
              out_valid_nxt = 1'b1;
              state_nxt     = S_RESP;
            end
            OP_RUN: begin
              rows_m1_nxt = (rows_cfg_r == 8'd0) ? '0 :
                            (int'(rows_cfg_r) > MAX_ROWS) ? RW'(MAX_ROWS - 1) :
                            RW'(rows_cfg_r - 8'd1);
              cols_m1_nxt = (cols_cfg_r == 8'd0) ? '0 :
                            (int'(cols_cfg_r) > MAX_COLS) ? CW'(MAX_COLS - 1) :
                            CW'(cols_cfg_r - 8'd1);
              last_base_nxt = AW'(int'(rows_m1_nxt) * MAX_COLS);
              sw_left_nxt   = sweeps_cfg_r;
              r_nxt         = '0;
              c_nxt         = '0;
              rbase_nxt     = '0;
              step_nxt      = '0;
              if (sweeps_cfg_r == 8'd0) begin
                out_valid_nxt = 1'b1;
                state_nxt     = S_RESP;
              end else begin
                state_nxt = S_NB;
              end
            end
            OP_READ:  state_nxt = S_LOOK;
            default:  state_nxt = S_CLR;
          endcase
        end
      end

      S_LOOK: state_nxt = S_LOOK2;

      S_LOOK2: begin
        if (req_in_r) begin
          out_value_nxt = (rd_x > I32_MAX_X) ? 32'(I32_MAX_X) :
                          (rd_x < I32_MIN_X) ? 32'(I32_MIN_X) : 32'(rd_x);
        end
        out_valid_nxt = 1'b1;
        state_nxt     = S_RESP;
      end

      S_NB: begin
        // Issue centre, up, down, left, right; take each word at the following step
        step_nxt = step_r + 1'b1;
        if (step_r == 3'd1) begin
          kind_c_nxt = kd_q;
          cen_nxt    = src_q;
          sum_nxt    = '0;
          cnt_nxt    = '0;
        end else if (step_r != 3'd0) begin
          if (kd_q != KIND_BLOCKED) begin
            sum_nxt = sum_r + SW'(src_q) - SW'(cen_r);
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        if (step_r == 3'd5) begin
          step_nxt  = '0;
          state_nxt = S_CALC;
        end
      end

      S_CALC: begin
        if (kind_c_r == KIND_BLOCKED) begin
          wdata_nxt = '0;
          state_nxt = S_WR;
        end else if (kind_c_r == KIND_SOURCE) begin
          wdata_nxt = src_sat;
          state_nxt = S_WR;
        end else if (cnt_r == 3'd3) begin
          state_nxt = S_DIV;
        end else begin
          t_nxt     = t_full[TW-1:0];
          state_nxt = S_MUL;
        end
      end

      S_DIV: begin
        if (div_done) begin
          t_nxt     = t_full[TW-1:0];
          state_nxt = S_MUL;
        end
      end

      S_MUL: begin
        prod_nxt  = PW'(t_mag) * PW'(coeff_cfg_r);
        tneg_nxt  = t_r[TW-1];
        state_nxt = S_SAT;
      end

      S_SAT: begin
        if (tneg_r) begin
          wdata_nxt = (q_mag > HALF_T) ? FW'(F_MIN_X) : FW'(-$signed(q_mag));
        end else begin
          wdata_nxt = (q_mag > HALF_T - 1'b1) ? FW'(F_MAX_X) : FW'(q_mag);
        end
        state_nxt = S_WR;
      end

      S_WR: begin
        // Advance to the next cell, the next sweep, or finish
        state_nxt = S_NB;
        if (c_r == cols_m1_r) begin
          c_nxt = '0;
          if (r_r == rows_m1_r) begin
            r_nxt       = '0;
            rbase_nxt   = '0;
            cur_a_nxt   = !cur_a_r;
            sw_left_nxt = sw_left_r - 8'd1;
            if (sw_left_r == 8'd1) begin
              out_valid_nxt = 1'b1;
              state_nxt     = S_RESP;
            end
          end else begin
            r_nxt     = r_r + 1'b1;
            rbase_nxt = rbase_r + AW'(MAX_COLS);
          end
        end else begin
          c_nxt = c_r + 1'b1;
        end
      end

      S_RESP: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_kind_r  <= 1'b1;
      clr_addr_r  <= '0;
      cur_a_r     <= 1'b1;
      sw_left_r   <= '0;
      r_r         <= '0;
      c_r         <= '0;
      rbase_r     <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_kind_r  <= clr_kind_nxt;
      clr_addr_r  <= clr_addr_nxt;
      cur_a_r     <= cur_a_nxt;
      sw_left_r   <= sw_left_nxt;
      r_r         <= r_nxt;
      c_r         <= c_nxt;
      rbase_r     <= rbase_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rows_m1_r   <= rows_m1_nxt;
    cols_m1_r   <= cols_m1_nxt;
    last_base_r <= last_base_nxt;
    req_addr_r  <= req_addr_nxt;
    req_in_r    <= req_in_nxt;
    kind_c_r    <= kind_c_nxt;
    cen_r       <= cen_nxt;
    sum_r       <= sum_nxt;
    cnt_r       <= cnt_nxt;
    t_r         <= t_nxt;
    prod_r      <= prod_nxt;
    tneg_r      <= tneg_nxt;
    wdata_r     <= wdata_nxt;
    out_value_r <= out_value_nxt;
  end

endmodule

/* rtl/gds_div.sv */
module gds_div #(
  parameter int W = 35
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  output logic         done,
  output logic [W-1:0] quotient
);

  localparam int H = (W + 1) / 2;
  localparam int K = W + 1;
  // ceil(2^K / 3); exact for any dividend up to 2^(W-1)
  localparam logic [2*H-1:0] RECIP = (2*H)'(((64'd1 << K) + 64'd2) / 64'd3);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [1:0]       step_r, step_nxt;
  logic [2*H-1:0]   x_r, x_nxt;
  logic [4*H-1:0]   acc_r, acc_nxt;
  logic [H-1:0]     xa, mb;
  logic [2*H-1:0]   pp;
  int               sh;

  // Divide by three as a reciprocal multiply, one half-by-half product a cycle
  always_comb begin
    xa = step_r[0] ? x_r[2*H-1:H] : x_r[H-1:0];
    mb = step_r[1] ? RECIP[2*H-1:H] : RECIP[H-1:0];
    pp = (2*H)'(xa) * (2*H)'(mb);
    case (step_r)
      2'd0:       sh = 0;
      2'd1, 2'd2: sh = H;
      default:    sh = 2 * H;
    endcase
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    x_nxt    = x_r;
    acc_nxt  = acc_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      x_nxt    = (2*H)'(dividend);
      acc_nxt  = '0;
    end else if (busy_r) begin
      acc_nxt  = acc_r + ((4*H)'(pp) << sh);
      step_nxt = step_r + 1'b1;
      if (step_r == 2'd3) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    x_r   <= x_nxt;
    acc_r <= acc_nxt;
  end

  assign done     = done_r;
  assign quotient = W'(acc_r >> K);

endmodule
